FILE: design/pts_pkg.sv
// shared types, codes and defaults for the priority task scheduler
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

	// default sizes
	localparam int unsigned NUM_TASKS_DEF   = 16;
	localparam int unsigned PRIO_LEVELS_DEF = 32;

	// width of the running task field in a result item
	localparam int unsigned RUN_W = 5;

	// request kinds
	typedef enum logic [1:0] {
		OP_ACTIVATE = 2'd0,
		OP_CHAIN    = 2'd1,
		OP_SCHEDULE = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_ID   = 3'd1,
		ST_LIMIT    = 3'd2,
		ST_NO_RUN   = 3'd3,
		ST_RESOURCE = 3'd4
	} status_t;

	// task states
	typedef enum logic [1:0] {
		TS_SUSPENDED = 2'd0,
		TS_READY     = 2'd1,
		TS_RUNNING   = 2'd2
	} task_state_t;

	// source of the task memory read address
	typedef enum logic [1:0] {
		SRC_ITEM = 2'd0,
		SRC_REQ  = 2'd1,
		SRC_RUN  = 2'd2
	} rd_src_t;

	// request item
	typedef struct packed {
		logic [1:0] op;
		logic [5:0] task_req;
		logic [4:0] base_priority;
		logic [7:0] max_activations;
		logic       holds_resources;
	} req_item_t;

	// result item
	typedef struct packed {
		logic [2:0]       status;
		logic [RUN_W-1:0] running_task;
		logic             switched;
		logic [1:0]       queried_state;
	} rsp_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_src_t rd_src;
		logic    check;
		logic    term;
		logic    act;
		logic    disp_rd;
		logic    disp;
		logic    disp_run;
		logic    out_load;
	} pts_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       err;
		logic       mask_any;
		logic       same_task;
	} pts_stat_t;

endpackage

`default_nettype wire

FILE: design/pts_dpath.sv
// scheduler datapath: task memories, ready slots, ready mask and running task
`timescale 1ns / 1ps
`default_nettype none

module pts_dpath #(
	parameter int unsigned NUM_TASKS   = pts_pkg::NUM_TASKS_DEF,
	parameter int unsigned PRIO_LEVELS = pts_pkg::PRIO_LEVELS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  pts_pkg::req_item_t req_item,
	input  pts_pkg::pts_cmd_t  cmd,
	output pts_pkg::pts_stat_t stat,
	output pts_pkg::rsp_item_t rsp_item
);
	import pts_pkg::*;

	localparam int unsigned TIW = $clog2(NUM_TASKS);
	localparam int unsigned TW  = $clog2(NUM_TASKS + 1);
	localparam int unsigned PW  = $clog2(PRIO_LEVELS);
	localparam logic [TW-1:0] NO_TASK = TW'(NUM_TASKS);

	function automatic logic [PRIO_LEVELS-1:0] prio_bit(input logic [PW-1:0] p);
		logic [PRIO_LEVELS-1:0] v;
		v = '0;
		v[p] = 1'b1;
		return v;
	endfunction

	// task memories, one entry per task, with valid bits standing in for reset
	logic [1:0]    st_mem  [NUM_TASKS];
	logic [7:0]    cnt_mem [NUM_TASKS];
	logic [PW-1:0] pri_mem [NUM_TASKS];
	logic [NUM_TASKS-1:0] st_vld_q;
	logic [NUM_TASKS-1:0] cp_vld_q;

	// ready slot memory, one entry per priority
	logic [TIW-1:0] slot_mem [PRIO_LEVELS];

	// control state
	logic [PRIO_LEVELS-1:0] mask_q, mask_d;
	logic [TW-1:0]          run_q, run_d;

	// payload registers
	req_item_t      item_q;
	logic [TW-1:0]  before_q;
	logic [1:0]     rd_st_q;
	logic [7:0]     rd_cnt_q;
	logic [PW-1:0]  rd_pri_q;
	logic [TIW-1:0] slot_q;
	logic [PW-1:0]  p_q;
	status_t        status_q;
	logic [1:0]     qstate_q;
	rsp_item_t      out_q;

	// write ports
	logic           st_we, cp_we, sl_we;
	logic [TIW-1:0] st_waddr, cp_waddr;
	logic [1:0]     st_wdata;
	logic [7:0]     cnt_wdata;
	logic [PW-1:0]  pri_wdata;
	logic [PW-1:0]  sl_waddr;
	logic [TIW-1:0] sl_wdata;

	logic [TIW-1:0] raddr;
	logic [TIW-1:0] t_idx, run_idx;
	logic           idok, run_valid, same_req_run, cnt_ge, base_ge;
	logic [PW-1:0]  clamp_p, act_pri, top_p;
	logic           act_susp, do_act, preempt, slot_is_run;
	logic [7:0]     term_cnt;
	status_t        chk_status;

	// request decode
	assign t_idx        = TIW'(item_q.task_req);
	assign run_idx      = run_q[TIW-1:0];
	assign idok         = {1'b0, item_q.task_req} < 7'(NUM_TASKS);
	assign run_valid    = run_q != NO_TASK;
	assign same_req_run = t_idx == run_idx;
	assign cnt_ge       = rd_cnt_q >= item_q.max_activations;
	assign base_ge      = {2'b00, item_q.base_priority} >= 7'(PRIO_LEVELS);
	assign clamp_p      = base_ge ? PW'(PRIO_LEVELS - 1) : PW'(item_q.base_priority);
	assign act_susp     = rd_st_q == TS_SUSPENDED;
	assign act_pri      = act_susp ? clamp_p : rd_pri_q;
	assign term_cnt     = (rd_cnt_q == 8'd0) ? 8'd0 : rd_cnt_q - 8'd1;
	assign slot_is_run  = run_valid && (slot_q == run_idx);
	assign preempt      = run_valid && (rd_st_q == TS_RUNNING);

	// request checks in priority order
	always_comb begin
		chk_status = ST_OK;
		case (item_q.op)
			OP_ACTIVATE: begin
				if (!idok) chk_status = ST_BAD_ID;
				else if (cnt_ge) chk_status = ST_LIMIT;
			end
			OP_CHAIN: begin
				if (!idok) chk_status = ST_BAD_ID;
				else if (!run_valid) chk_status = ST_NO_RUN;
				else if (item_q.holds_resources) chk_status = ST_RESOURCE;
				else if (!same_req_run && cnt_ge) chk_status = ST_LIMIT;
			end
			OP_SCHEDULE: begin
				if (!run_valid) chk_status = ST_NO_RUN;
				else if (item_q.holds_resources) chk_status = ST_RESOURCE;
			end
			default: begin
				if (!idok) chk_status = ST_BAD_ID;
			end
		endcase
	end

	assign do_act = (cmd.check && chk_status == ST_OK && item_q.op == OP_ACTIVATE) || cmd.act;

	// highest non-empty ready slot
	always_comb begin
		top_p = '0;
		for (int i = 0; i < PRIO_LEVELS; i++) begin
			if (mask_q[i]) top_p = PW'(i);
		end
	end

	// read address select
	always_comb begin
		case (cmd.rd_src)
			SRC_ITEM: raddr = (req_item.op == OP_SCHEDULE) ? run_idx : TIW'(req_item.task_req);
			SRC_REQ:  raddr = t_idx;
			SRC_RUN:  raddr = run_idx;
			default:  raddr = '0;
		endcase
	end

	// write port and next state logic
	always_comb begin
		st_we     = 1'b0;
		st_waddr  = t_idx;
		st_wdata  = TS_READY;
		cp_we     = 1'b0;
		cp_waddr  = t_idx;
		cnt_wdata = rd_cnt_q + 8'd1;
		pri_wdata = act_pri;
		sl_we     = 1'b0;
		sl_waddr  = clamp_p;
		sl_wdata  = t_idx;
		mask_d    = mask_q;
		run_d     = run_q;

		// activate one: count up, queue a suspended task at its new priority
		if (do_act) begin
			cp_we = 1'b1;
			if (act_susp) begin
				st_we  = 1'b1;
				sl_we  = 1'b1;
				mask_d = mask_q | prio_bit(clamp_p);
			end
			if (cmd.act) run_d = NO_TASK;
		end

		// schedule: put the running task back into its slot
		if (cmd.check && chk_status == ST_OK && item_q.op == OP_SCHEDULE) begin
			st_we    = 1'b1;
			st_waddr = run_idx;
			sl_we    = 1'b1;
			sl_waddr = rd_pri_q;
			sl_wdata = run_idx;
			mask_d   = mask_q | prio_bit(rd_pri_q);
		end

		// chain: running task gives up one activation
		if (cmd.term) begin
			cp_we     = 1'b1;
			cp_waddr  = run_idx;
			cnt_wdata = term_cnt;
			pri_wdata = rd_pri_q;
			st_we     = 1'b1;
			st_waddr  = run_idx;
			st_wdata  = (term_cnt != 8'd0) ? TS_READY : TS_SUSPENDED;
			if (term_cnt != 8'd0) begin
				sl_we    = 1'b1;
				sl_waddr = rd_pri_q;
				sl_wdata = run_idx;
				mask_d   = mask_q | prio_bit(rd_pri_q);
			end
		end

		// dispatch: take the top slot, requeue a preempted task
		if (cmd.disp) begin
			mask_d = mask_q & ~prio_bit(p_q);
			if (slot_is_run) begin
				st_we    = 1'b1;
				st_waddr = slot_q;
				st_wdata = TS_RUNNING;
			end else begin
				if (preempt) begin
					st_we    = 1'b1;
					st_waddr = run_idx;
					st_wdata = TS_READY;
					sl_we    = 1'b1;
					sl_waddr = rd_pri_q;
					sl_wdata = run_idx;
					mask_d   = (mask_q & ~prio_bit(p_q)) | prio_bit(rd_pri_q);
				end
				run_d = TW'(slot_q);
			end
		end

		// new running task takes the processor
		if (cmd.disp_run) begin
			st_we    = 1'b1;
			st_waddr = run_idx;
			st_wdata = TS_RUNNING;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			run_q    <= NO_TASK;
			st_vld_q <= '0;
			cp_vld_q <= '0;
		end else begin
			mask_q <= mask_d;
			run_q  <= run_d;
			if (st_we) st_vld_q[st_waddr] <= 1'b1;
			if (cp_we) cp_vld_q[cp_waddr] <= 1'b1;
		end
	end

	// task memory writes
	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_waddr] <= st_wdata;
		if (cp_we) begin
			cnt_mem[cp_waddr] <= cnt_wdata;
			pri_mem[cp_waddr] <= pri_wdata;
		end
	end

	// task memory read with write bypass, unwritten entries read as reset
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			if (st_we && st_waddr == raddr) rd_st_q <= st_wdata;
			else if (st_vld_q[raddr]) rd_st_q <= st_mem[raddr];
			else rd_st_q <= TS_SUSPENDED;
			if (cp_we && cp_waddr == raddr) begin
				rd_cnt_q <= cnt_wdata;
				rd_pri_q <= pri_wdata;
			end else if (cp_vld_q[raddr]) begin
				rd_cnt_q <= cnt_mem[raddr];
				rd_pri_q <= pri_mem[raddr];
			end else begin
				rd_cnt_q <= 8'd0;
				rd_pri_q <= '0;
			end
		end
	end

	// ready slot memory
	always_ff @(posedge clk) begin
		if (sl_we) slot_mem[sl_waddr] <= sl_wdata;
		if (cmd.disp_rd) begin
			slot_q <= slot_mem[top_p];
			p_q    <= top_p;
		end
	end

	// item, check result and result item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= req_item;
			before_q <= run_q;
		end
		if (cmd.check) begin
			status_q <= chk_status;
			qstate_q <= (item_q.op == OP_QUERY && idok) ? rd_st_q : 2'd0;
		end
		if (cmd.out_load) begin
			out_q.status        <= status_q;
			out_q.running_task  <= RUN_W'(run_q);
			out_q.switched      <= run_q != before_q;
			out_q.queried_state <= qstate_q;
		end
	end

	assign stat.op        = item_q.op;
	assign stat.err       = chk_status != ST_OK;
	assign stat.mask_any  = |mask_q;
	assign stat.same_task = slot_is_run;
	assign rsp_item       = out_q;

endmodule

`default_nettype wire

FILE: design/pts_ctrl.sv
// scheduler controller: request sequencing and result handshake
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output pts_pkg::pts_cmd_t  cmd,
	input  pts_pkg::pts_stat_t stat
);
	import pts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_TERM,
		S_ACT,
		S_DRD,
		S_DISP,
		S_DRUN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	// commands per step
	always_comb begin
		cmd = '0;
		cmd.rd_src = SRC_ITEM;
		case (state_q)
			S_IDLE: begin
				cmd.load  = req_valid;
				cmd.rd_en = req_valid;
			end
			S_CHECK: begin
				cmd.check  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_src = SRC_RUN;
			end
			S_TERM: begin
				cmd.term   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_src = SRC_REQ;
			end
			S_ACT: cmd.act = 1'b1;
			S_DRD: begin
				cmd.disp_rd = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_src  = SRC_RUN;
			end
			S_DISP: cmd.disp = 1'b1;
			S_DRUN: cmd.disp_run = 1'b1;
			S_FIN: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// step sequence and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result item replaces one that leaves on this edge
			if (state_q == S_FIN && out_free) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stat.err || stat.op == OP_QUERY) state_q <= S_FIN;
					else if (stat.op == OP_CHAIN) state_q <= S_TERM;
					else state_q <= S_DRD;
				end
				S_TERM: state_q <= S_ACT;
				S_ACT: state_q <= S_DRD;
				S_DRD: begin
					state_q <= stat.mask_any ? S_DISP : S_FIN;
				end
				S_DISP: begin
					state_q <= stat.same_task ? S_FIN : S_DRUN;
				end
				S_DRUN: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/priority_task_scheduler_core.sv
// Priority task scheduler top level: sequencing controller plus task/slot datapath.
// One item in flight; the next item is taken only once its result is registered,
//   and a dispatch spends a slot memory read and up to two task state writes.
// Reset: all tasks suspended with zero counts, ready mask empty, no running task.
`timescale 1ns / 1ps
`default_nettype none

module priority_task_scheduler_core #(
	parameter int unsigned NUM_TASKS   = pts_pkg::NUM_TASKS_DEF,
	parameter int unsigned PRIO_LEVELS = pts_pkg::PRIO_LEVELS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  pts_pkg::req_item_t req_item,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output pts_pkg::rsp_item_t rsp_item
);
	import pts_pkg::*;

	pts_cmd_t  cmd;
	pts_stat_t stat;

	// sequencing
	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// task state, ready slots and dispatch
	pts_dpath #(
		.NUM_TASKS   (NUM_TASKS),
		.PRIO_LEVELS (PRIO_LEVELS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_item (req_item),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_item (rsp_item)
	);

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous item still in progress");

	// a rejected request never changes the running task
	a_err_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status != ST_OK |-> !rsp_item.switched)
		else $error("failed request switched the running task");

	// a query result comes only from a good query
	a_qstate_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.queried_state != 2'd0 |->
		rsp_item.status == ST_OK && !rsp_item.switched)
		else $error("queried state set on a non-query or failed item");

	// at most one datapath action per cycle
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.check, cmd.term, cmd.act, cmd.disp_rd, cmd.disp,
			cmd.disp_run, cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// self-checking testbench for the priority task scheduler core
`timescale 1ns / 1ps

module testbench;
	import pts_pkg::*;

	localparam int unsigned NT = NUM_TASKS_DEF;
	localparam int unsigned PL = PRIO_LEVELS_DEF;
	localparam int unsigned SLOT_W = $clog2(NT);
	localparam logic [RUN_W-1:0] NO_TASK = RUN_W'(NT);
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// bench signals; the ones the bench drives are known from time zero
	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	req_item_t req_item = '0;
	logic      rsp_stall = 1'b0;
	logic      req_stall;
	logic      rsp_valid;
	rsp_item_t rsp_item;

	int        snd_idle_pct = 0;
	int        rcv_idle_pct = 0;
	int        bad_count = 0;
	int        cycle_count = 0;
	rsp_item_t sched_rsp_q[$];

	// scheduler state as predicted by the bench
	task_state_t        tk_state[NT];
	logic [7:0]         tk_count[NT];
	logic [4:0]         tk_prio[NT];
	logic [SLOT_W-1:0]  slot_task[PL];
	logic [PL-1:0]      slot_mask;
	logic [RUN_W-1:0]   run_idx;

	// per-task habits used by the random items
	logic [4:0] prof_prio[NT];
	logic [7:0] prof_limit[NT];

	always #6 clk = ~clk;

	priority_task_scheduler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// scheduler prediction
	function automatic void clear_sched();
		for (int i = 0; i < NT; i++) begin
			tk_state[i] = TS_SUSPENDED;
			tk_count[i] = '0;
			tk_prio[i] = '0;
		end
		for (int p = 0; p < PL; p++) begin
			slot_task[p] = '0;
		end
		slot_mask = '0;
		run_idx = NO_TASK;
	endfunction

	function automatic int unsigned sat_prio(input int unsigned p);
		return (p >= PL) ? PL - 1 : p;
	endfunction

	function automatic void make_ready(input int unsigned t);
		int unsigned p;
		p = sat_prio(tk_prio[t]);
		tk_state[t] = TS_READY;
		slot_task[p] = SLOT_W'(t);
		slot_mask[p] = 1'b1;
	endfunction

	// a slot is freed only if it still holds this task
	function automatic void leave_slot(input int unsigned t);
		int unsigned p;
		p = sat_prio(tk_prio[t]);
		if (slot_mask[p] && slot_task[p] == t) begin
			slot_mask[p] = 1'b0;
		end
	endfunction

	function automatic int unsigned top_ready();
		for (int p = PL - 1; p >= 0; p--) begin
			if (slot_mask[p]) begin
				return slot_task[p];
			end
		end
		return NT;
	endfunction

	// pick the highest ready task, preempted task goes back to its slot
	function automatic void dispatch_top();
		int unsigned nxt;
		nxt = top_ready();
		if (nxt == NT) begin
			return;
		end
		if (nxt == run_idx) begin
			leave_slot(nxt);
			tk_state[nxt] = TS_RUNNING;
			return;
		end
		leave_slot(nxt);
		if (run_idx < NT && tk_state[run_idx] == TS_RUNNING) begin
			make_ready(run_idx);
		end
		tk_state[nxt] = TS_RUNNING;
		run_idx = RUN_W'(nxt);
	endfunction

	function automatic void add_activation(input int unsigned t, input logic [4:0] base);
		tk_count[t] = tk_count[t] + 8'd1;
		if (tk_state[t] == TS_SUSPENDED) begin
			tk_prio[t] = 5'(sat_prio(base));
			make_ready(t);
		end
	endfunction

	function automatic rsp_item_t scheduler_step(input req_item_t rq);
		rsp_item_t        r;
		logic [RUN_W-1:0] prev;
		int unsigned      t;
		int unsigned      cur;
		logic             id_ok;
		prev = run_idx;
		r = '0;
		r.status = ST_OK;
		id_ok = rq.task_req < NT;
		t = id_ok ? rq.task_req : 0;
		case (op_t'(rq.op))
			OP_ACTIVATE: begin
				if (!id_ok) r.status = ST_BAD_ID;
				else if (tk_count[t] >= rq.max_activations) r.status = ST_LIMIT;
				else begin
					add_activation(t, rq.base_priority);
					dispatch_top();
				end
			end
			OP_CHAIN: begin
				if (!id_ok) r.status = ST_BAD_ID;
				else if (run_idx >= NT) r.status = ST_NO_RUN;
				else if (rq.holds_resources) r.status = ST_RESOURCE;
				else if (t != run_idx && tk_count[t] >= rq.max_activations) r.status = ST_LIMIT;
				else begin
					// running task gives up one activation, then the target starts
					cur = run_idx;
					if (tk_count[cur] > 0) tk_count[cur] = tk_count[cur] - 8'd1;
					if (tk_count[cur] > 0) make_ready(cur);
					else tk_state[cur] = TS_SUSPENDED;
					add_activation(t, rq.base_priority);
					run_idx = NO_TASK;
					dispatch_top();
				end
			end
			OP_SCHEDULE: begin
				if (run_idx >= NT) r.status = ST_NO_RUN;
				else if (rq.holds_resources) r.status = ST_RESOURCE;
				else begin
					make_ready(run_idx);
					dispatch_top();
				end
			end
			default: begin
				if (!id_ok) r.status = ST_BAD_ID;
				else r.queried_state = tk_state[t];
			end
		endcase
		r.running_task = run_idx;
		r.switched = (run_idx != prev);
		return r;
	endfunction

	// item builders
	function automatic req_item_t mk_req(input op_t op, input logic [5:0] tsk,
			input logic [4:0] base, input logic [7:0] lim, input logic held);
		req_item_t rq;
		rq.op = op;
		rq.task_req = tsk;
		rq.base_priority = base;
		rq.max_activations = lim;
		rq.holds_resources = held;
		return rq;
	endfunction

	function automatic void pick_profiles();
		for (int i = 0; i < NT; i++) begin
			prof_prio[i] = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 9));
			prof_limit[i] = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 4));
		end
	endfunction

	// mostly well-formed requests on valid tasks, some pure noise
	function automatic req_item_t random_request();
		req_item_t   rq;
		int unsigned roll;
		int unsigned t;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			rq = req_item_t'($urandom());
			return rq;
		end
		roll = $urandom_range(0, 99);
		if (roll < 35) rq.op = OP_ACTIVATE;
		else if (roll < 60) rq.op = OP_CHAIN;
		else if (roll < 75) rq.op = OP_SCHEDULE;
		else rq.op = OP_QUERY;
		t = $urandom_range(0, NT - 1);
		rq.task_req = 6'(t);
		rq.base_priority = ($urandom_range(0, 9) == 0) ? 5'($urandom()) : prof_prio[t];
		rq.max_activations = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : prof_limit[t];
		rq.holds_resources = ($urandom_range(0, 19) == 0);
		return rq;
	endfunction

	// send one item, entered and left at a falling edge
	task automatic send_item(input req_item_t it);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (req_stall !== 1'b0);
		sched_rsp_q.push_back(scheduler_step(it));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sched_rsp_q.size() != 0) @(negedge clk);
	endtask

	// receiver stall
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// result checking
	task automatic note_failure(input string msg);
		bad_count++;
		if (bad_count <= MAX_REPORTS) $display("mismatch: %s", msg);
	endtask

	task automatic check_response(input rsp_item_t got);
		rsp_item_t want;
		if (sched_rsp_q.size() == 0) begin
			note_failure($sformatf("unexpected item status %0d running %0d",
				got.status, got.running_task));
			return;
		end
		want = sched_rsp_q.pop_front();
		if (got.status !== want.status)
			note_failure($sformatf("status exp %0d got %0d", want.status, got.status));
		if (got.running_task !== want.running_task)
			note_failure($sformatf("running_task exp %0d got %0d",
				want.running_task, got.running_task));
		if (got.switched !== want.switched)
			note_failure($sformatf("switched exp %0d got %0d", want.switched, got.switched));
		if (got.queried_state !== want.queried_state)
			note_failure($sformatf("queried_state exp %0d got %0d",
				want.queried_state, got.queried_state));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) check_response(rsp_item);
	end

	// error order, limits, preemption, slot overwrite and chaining
	task automatic test_directed();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		send_item(mk_req(OP_SCHEDULE, 6'd0, 5'd0, 8'd1, 1'b0));
		send_item(mk_req(OP_CHAIN, 6'd4, 5'd3, 8'd1, 1'b1));
		send_item(mk_req(OP_CHAIN, 6'd63, 5'd3, 8'd1, 1'b0));
		send_item(mk_req(OP_QUERY, 6'd40, 5'd0, 8'd1, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd16, 5'd1, 8'd1, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd3, 5'd5, 8'd0, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd3, 5'd5, 8'd2, 1'b0));
		send_item(mk_req(OP_QUERY, 6'd3, 5'd0, 8'd1, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd3, 5'd5, 8'd1, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd3, 5'd5, 8'd2, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd5, 5'd31, 8'd255, 1'b0));
		send_item(mk_req(OP_QUERY, 6'd3, 5'd0, 8'd1, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd7, 5'd0, 8'd1, 1'b0));
		send_item(mk_req(OP_SCHEDULE, 6'd0, 5'd0, 8'd1, 1'b1));
		send_item(mk_req(OP_CHAIN, 6'd7, 5'd0, 8'd1, 1'b1));
		send_item(mk_req(OP_CHAIN, 6'd7, 5'd0, 8'd1, 1'b0));
		send_item(mk_req(OP_SCHEDULE, 6'd63, 5'd31, 8'd255, 1'b0));
		send_item(mk_req(OP_ACTIVATE, 6'd9, 5'd5, 8'd1, 1'b0));
		send_item(mk_req(OP_CHAIN, 6'd5, 5'd31, 8'd1, 1'b0));
		send_item(mk_req(OP_CHAIN, 6'd2, 5'd20, 8'd3, 1'b0));
		send_item(mk_req(OP_CHAIN, 6'd2, 5'd10, 8'd1, 1'b0));
		send_item(mk_req(OP_CHAIN, 6'd15, 5'd0, 8'd255, 1'b0));
		send_item(mk_req(OP_QUERY, 6'd15, 5'd0, 8'd1, 1'b0));
		send_item(mk_req(OP_QUERY, 6'd0, 5'd0, 8'd1, 1'b0));
	endtask

	task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		pick_profiles();
		for (int i = 0; i < n; i++) begin
			send_item(random_request());
		end
	endtask

	// sender holds off until every result is back, then resumes
	task automatic test_drain_pause();
		wait_drained();
		for (int i = 0; i < 20; i++) begin
			send_item(random_request());
		end
	endtask

	initial begin
		clear_sched();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(300, 8, 64);
		test_drain_pause();
		test_random(300, 64, 8);
		test_random(300, 0, 0);
		wait_drained();
		repeat (16) @(posedge clk);
		if (bad_count == 0 && sched_rsp_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
